// ----- src/bpa_pkg.sv -----
package bpa_pkg;

	localparam int NUM_PAGES = 4096;
	localparam int MAX_RUN   = 64;
	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = NUM_PAGES / WORD_W;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int ADDR_W    = $clog2(NUM_WORDS);
	localparam int PAGE_W    = 12;
	localparam int LIMIT_W   = 13;
	localparam int COUNT_W   = 7;
	localparam int LG_W      = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [ADDR_W-1:0]  waddr_t;
	typedef logic [LIMIT_W-1:0] page_t;

	typedef struct packed {
		logic               op;
		logic [PAGE_W-1:0]  start_page;
		logic [COUNT_W-1:0] page_count;
	} req_t;

	typedef struct packed {
		logic              success;
		logic [PAGE_W-1:0] first_page;
	} rsp_t;

	typedef struct packed {
		logic   en;
		waddr_t addr;
		word_t  word;
	} map_wr_t;

	// Bits of word w whose page number is at or above x.
	function automatic word_t ge_mask(input page_t x, input waddr_t w);
		logic [LIMIT_W-BIT_W-1:0] upper;
		word_t                    m;
		upper = x[LIMIT_W-1:BIT_W];
		if (upper > (LIMIT_W-BIT_W)'(w)) begin
			m = '0;
		end else if (upper < (LIMIT_W-BIT_W)'(w)) begin
			m = '1;
		end else begin
			m = word_t'('1) << x[BIT_W-1:0];
		end
		return m;
	endfunction

	// Bits of word w whose page number lies in [lo, hi).
	function automatic word_t range_mask(input waddr_t w, input page_t lo, input page_t hi);
		return ge_mask(lo, w) & ~ge_mask(hi, w);
	endfunction

endpackage

// ----- src/bpa_map.sv -----
module bpa_map (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  bpa_pkg::waddr_t  rd_addr,
	output bpa_pkg::word_t   rd_word,
	input  bpa_pkg::map_wr_t wr
);
	import bpa_pkg::*;

	word_t                mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] written_q;
	word_t                rdata_q;
	logic                 rvalid_q;

	// Storage: no reset on the array itself.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Never-written words read as all used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				written_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_word = rvalid_q ? rdata_q : '1;

endmodule

// ----- src/bpa_runfind.sv -----
module bpa_runfind (
	input  bpa_pkg::word_t           cur_free,
	input  bpa_pkg::word_t           prev_free,
	input  logic [bpa_pkg::LG_W-1:0] lg,
	input  logic [bpa_pkg::BIT_W-1:0] rem,
	output logic                     hit,
	output logic [bpa_pkg::BIT_W-1:0] pos
);
	import bpa_pkg::*;

	localparam int EXT_W  = 2 * WORD_W;
	localparam int LEVELS = BIT_W + 1;

	logic [EXT_W-1:0]  lvl [LEVELS];
	logic [EXT_W-1:0]  sel;
	logic [EXT_W-1:0]  win;
	logic [WORD_W-1:0] ends;

	// lvl[k] bit i: the 2**k pages ending at i are all free.
	always_comb begin
		lvl[0] = {cur_free, prev_free};
		for (int k = 1; k < LEVELS; k++) begin
			lvl[k] = lvl[k-1] & (lvl[k-1] << (1 << (k-1)));
		end
	end

	// Two overlapping power-of-two windows cover any run length.
	always_comb begin
		sel = '0;
		for (int k = 0; k < LEVELS; k++) begin
			if (lg == LG_W'(k)) begin
				sel = lvl[k];
			end
		end
		win  = sel & (sel << rem);
		ends = win[EXT_W-1:WORD_W];
	end

	// Lowest run end within the current word.
	always_comb begin
		hit = |ends;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (ends[i]) begin
				pos = BIT_W'(i);
			end
		end
	end

endmodule

// ----- src/bitmap_page_allocator_top.sv -----
// Bitmap first-fit page allocator: one used/free bit per page, held as 64 words of 64 bits.
// Request channel (req_valid / req_stall / req_data): a transaction is taken when req_valid
// is high and req_stall is low. op = alloc searches from page 0 for the first run of
// page_count free pages below page_limit, marks it used and returns its first page.
// op = free clears page_count pages from start_page, skipping pages at or above the limit.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response per request.
// Sequence: alloc reads and then searches each map word scanned, from word 0 up to all
// 64 words, then marks the run (in one or two words) and responds.
// A free reads and writes back each word touched, at most three words, then responds;
// a request that touches no page goes straight to the response state.
// The map memory has one read port, one write port and a registered read;
// one request is in flight at a time, req_stall is high while it is, and the block
// returns to idle before it accepts the next request.
// The response register parts the channels: a new request is accepted while an older
// response is still stalled; the block then holds its finished result until rsp_stall drops.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes page_limit; values above the
// page count act as the page count.
// Reset: page_limit returns to 4096 and every page reads as used at once (per-word
// written flags, no clearing pass); usable ranges are released with free requests.
module bitmap_page_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  bpa_pkg::req_t               req_data,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output bpa_pkg::rsp_t               rsp_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bpa_pkg::LIMIT_W-1:0] cfg_data
);
	import bpa_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ARD   = 3'd1;
	localparam logic [2:0] ST_AEV   = 3'd2;
	localparam logic [2:0] ST_MARK  = 3'd3;
	localparam logic [2:0] ST_MARK2 = 3'd4;
	localparam logic [2:0] ST_FRD   = 3'd5;
	localparam logic [2:0] ST_FWR   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]         state_q;
	page_t              limit_q;
	page_t              lim_q;
	page_t              lo_q;
	page_t              hi_q;
	waddr_t             w_q;
	waddr_t             wend_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [LG_W-1:0]    lg_q;
	logic [BIT_W-1:0]   rem_q;
	logic [BIT_W-1:0]   pos_q;
	word_t              cur_q;
	word_t              prev_q;
	word_t              fprev_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	logic               accept;
	page_t              eff_lim;
	page_t              free_end;
	page_t              free_hi;
	logic [LG_W-1:0]    req_lg;
	logic [BIT_W-1:0]   req_rem;
	page_t              run_start;
	page_t              run_end;
	logic               rd_en;
	word_t              rd_word;
	word_t              cur_free;
	logic               hit;
	logic [BIT_W-1:0]   hit_pos;
	map_wr_t            wr;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Clamp the limit to the map size; bound a free run by start + count and the limit.
	always_comb begin
		eff_lim  = (limit_q > page_t'(NUM_PAGES)) ? page_t'(NUM_PAGES) : limit_q;
		free_end = page_t'(req_data.start_page) + page_t'(req_data.page_count);
		free_hi  = (free_end < eff_lim) ? free_end : eff_lim;
	end

	// Split the run length into its top power of two and the remainder.
	always_comb begin
		req_lg = '0;
		for (int k = 0; k < COUNT_W; k++) begin
			if (req_data.page_count[k]) begin
				req_lg = LG_W'(k);
			end
		end
		req_rem = BIT_W'(page_t'(req_data.page_count) - (page_t'(1) << req_lg));
	end

	// Free pages of the word just read, with pages past the limit forced used.
	assign cur_free = ~rd_word & ~ge_mask(lim_q, w_q);

	bpa_runfind u_runfind (
		.cur_free  (cur_free),
		.prev_free (fprev_q),
		.lg        (lg_q),
		.rem       (rem_q),
		.hit       (hit),
		.pos       (hit_pos)
	);

	assign run_start = {1'b0, w_q, pos_q} + page_t'(1) - page_t'(cnt_q);
	assign run_end   = run_start + page_t'(cnt_q);

	assign rd_en = (state_q == ST_ARD) || (state_q == ST_FRD);

	// Write-back port: mark in the hit word, mark the tail of the previous word,
	// or clear the freed range.
	always_comb begin
		wr = '0;
		case (state_q)
			ST_MARK: begin
				wr.en   = 1'b1;
				wr.addr = w_q;
				wr.word = cur_q | range_mask(w_q, run_start, run_end);
			end
			ST_MARK2: begin
				wr.en   = 1'b1;
				wr.addr = w_q - waddr_t'(1);
				wr.word = prev_q | range_mask(w_q - waddr_t'(1), lo_q, hi_q);
			end
			ST_FWR: begin
				wr.en   = 1'b1;
				wr.addr = w_q;
				wr.word = rd_word & ~range_mask(w_q, lo_q, hi_q);
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	bpa_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (w_q),
		.rd_word (rd_word),
		.wr      (wr)
	);

	// Control and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= page_t'(NUM_PAGES);
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			// Load the finished result once the register is free; drop valid once taken.
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_data.op == OP_FREE) begin
							state_q <= (free_hi > page_t'(req_data.start_page)) ? ST_FRD : ST_DONE;
						end else if (req_data.page_count != '0 &&
								req_data.page_count <= COUNT_W'(MAX_RUN)) begin
							state_q <= ST_ARD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_ARD: begin
					state_q <= ST_AEV;
				end
				ST_AEV: begin
					if (hit) begin
						state_q <= ST_MARK;
					end else if (w_q == waddr_t'(NUM_WORDS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_ARD;
					end
				end
				ST_MARK: begin
					state_q <= (run_start[LIMIT_W-2:BIT_W] != w_q) ? ST_MARK2 : ST_DONE;
				end
				ST_MARK2: begin
					state_q <= ST_DONE;
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					state_q <= (w_q == wend_q) ? ST_DONE : ST_FRD;
				end
				ST_DONE: begin
					// Hold the result while the previous response is still stalled.
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lim_q            <= eff_lim;
				cnt_q            <= req_data.page_count;
				lg_q             <= req_lg;
				rem_q            <= req_rem;
				fprev_q          <= '0;
				prev_q           <= '1;
				res_q.success    <= (req_data.op == OP_FREE);
				res_q.first_page <= '0;
				if (req_data.op == OP_FREE) begin
					lo_q   <= page_t'(req_data.start_page);
					hi_q   <= free_hi;
					w_q    <= req_data.start_page[PAGE_W-1:BIT_W];
					wend_q <= ADDR_W'((free_hi - page_t'(1)) >> BIT_W);
				end else begin
					w_q <= '0;
				end
			end
			ST_AEV: begin
				if (hit) begin
					pos_q <= hit_pos;
					cur_q <= rd_word;
				end else begin
					fprev_q <= cur_free;
					prev_q  <= rd_word;
					w_q     <= w_q + waddr_t'(1);
				end
			end
			ST_MARK: begin
				lo_q             <= run_start;
				hi_q             <= run_end;
				res_q.success    <= 1'b1;
				res_q.first_page <= run_start[PAGE_W-1:0];
			end
			ST_FWR: begin
				if (w_q != wend_q) begin
					w_q <= w_q + waddr_t'(1);
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
